/* design/bsvg_pkg.sv */
package bsvg_pkg;

   // volume extent per axis
   localparam int MAX_X = 64;
   localparam int MAX_Y = 64;
   localparam int MAX_Z = 64;

   localparam int X_W = $clog2(MAX_X);
   localparam int Y_W = $clog2(MAX_Y);
   localparam int Z_W = $clog2(MAX_Z);

   localparam int unsigned STORE_DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // item modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_DX   = 2'd1;
   localparam logic [1:0] MODE_DY   = 2'd2;
   localparam logic [1:0] MODE_DZ   = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [2:0] CSR_SIZE_X   = 3'd3;
   localparam logic [2:0] CSR_SIZE_Y   = 3'd4;
   localparam logic [2:0] CSR_SIZE_Z   = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WEIGHT,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               start;
      logic               deriv;
      logic signed [18:0] d;
   } tap_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] w;
   } tap_rsp_type;

endpackage

/* design/bsvg_tap.sv */
module bsvg_tap (
   input  logic                 clock,
   input  logic                 reset,
   input  bsvg_pkg::tap_req_type tap_req,
   output bsvg_pkg::tap_rsp_type tap_rsp
);

   localparam logic [3:0] LAST = 4'd8;

   logic               busy_ff, done_ff;
   logic [3:0]         cnt_ff;
   logic signed [18:0] d_ff;
   logic               deriv_ff;
   logic [17:0]        a_ff;
   logic [16:0]        s_ff;
   logic               inner_ff, zero_ff, neg_ff;
   logic [32:0]        m1_ff;
   logic [48:0]        m2_ff;
   logic [35:0]        u_ff;
   logic [1:0]         rem_ff;

   logic [17:0]        a_in;
   logic [16:0]        s_in;
   logic [32:0]        m1_in;
   logic [48:0]        m2_in;
   logic signed [55:0] n_in;
   logic [35:0]        lin_in;
   logic [35:0]        u_in;
   logic [1:0]         rem_in;

   // magnitude, branch, first square and cube
   always_comb begin
      a_in  = d_ff[18] ? 18'(-d_ff) : 18'(d_ff);
      s_in  = (a_in < 18'd65536) ? 17'(a_in) : 17'(18'd131072 - a_in);
      m1_in = 33'(s_in) * 33'(s_in);
      m2_in = 49'(m1_ff) * 49'(s_ff);
   end

   // spline numerator, then scale down to a value divided by three
   always_comb begin
      logic signed [55:0] m1s, m2s, as, mag, t;
      m1s = signed'(56'(m1_ff));
      m2s = signed'(56'(m2_ff));
      as  = signed'(56'(a_ff));
      mag = '0;
      if (zero_ff) begin
         n_in = '0;
      end else if (inner_ff && !deriv_ff) begin
         n_in = (56'sd1 <<< 50) - 56'sd6 * (m1s <<< 16) + 56'sd3 * m2s;
      end else if (inner_ff) begin
         mag  = 56'sd9 * (m1s <<< 16) - 56'sd12 * (as <<< 32);
         n_in = neg_ff ? -mag : mag;
      end else if (!deriv_ff) begin
         n_in = m2s;
      end else begin
         mag  = -(56'sd3 * (m1s <<< 16));
         n_in = neg_ff ? -mag : mag;
      end
      t      = (n_in + 56'sd786432) >>> 19;
      lin_in = 36'(t + 56'sd51539607552);
   end

   // six quotient bits per cycle of the divide by three
   always_comb begin
      logic [1:0]  r;
      logic [2:0]  r3;
      logic [35:0] uu;
      logic        qb;
      r  = rem_ff;
      uu = u_ff;
      for (int k = 0; k < 6; k++) begin
         r3 = {r, uu[35]};
         qb = (r3 >= 3'd3);
         r  = qb ? 2'(r3 - 3'd3) : r3[1:0];
         uu = {uu[34:0], qb};
      end
      u_in   = uu;
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == LAST);
         if (tap_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == LAST) busy_ff <= 1'b0;
            else cnt_ff <= cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tap_req.start) begin
         d_ff     <= tap_req.d;
         deriv_ff <= tap_req.deriv;
      end else if (busy_ff) begin
         case (cnt_ff)
            4'd0: begin
               a_ff     <= a_in;
               s_ff     <= s_in;
               m1_ff    <= m1_in;
               inner_ff <= (a_in < 18'd65536);
               zero_ff  <= (a_in >= 18'd131072);
               neg_ff   <= d_ff[18];
            end
            4'd1: m2_ff <= m2_in;
            4'd2: begin
               u_ff   <= lin_in;
               rem_ff <= 2'd0;
            end
            default: begin
               u_ff   <= u_in;
               rem_ff <= rem_in;
            end
         endcase
      end
   end

   assign tap_rsp.done = done_ff;
   assign tap_rsp.w    = signed'(32'(u_ff - 36'h4_0000_0000));

endmodule

/* design/bspline_volume_gradient_sample.sv */
// load: written straight into the coefficient memory, no transfer out
// query: one item at a time from accept to result; the twelve 1D weights go one after
//   another through the shared weight unit, then the 64 coefficient reads use the single
//   memory read port, one per cycle, and then the tap pipeline drains
// a query with a neighbour outside the volume computes no weights and reads no coefficients
// reset clears control and config (origin 0, size 64); the coefficient memory is not cleared
module bspline_volume_gradient_sample (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [17:0]        req_load_address,
   input  logic signed [31:0] req_load_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_gradient,
   output logic               rsp_out_of_range,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int ADDR_W = bsvg_pkg::ADDR_W;
   localparam logic [ADDR_W-1:0] PLANE = ADDR_W'(bsvg_pkg::MAX_X * bsvg_pkg::MAX_Y);
   localparam logic [ADDR_W-1:0] ROW   = ADDR_W'(bsvg_pkg::MAX_X);

   // round half up from Q.60 to Q.30
   function automatic logic signed [31:0] rnd30(logic signed [63:0] v);
      logic signed [63:0] t;
      t = (v + 64'sd536870912) >>> 30;
      return 32'(t);
   endfunction

   // distance from the position to neighbour i, Q.16
   function automatic logic signed [18:0] tap_dist(logic [15:0] frac, logic [1:0] i);
      logic signed [18:0] off;
      case (i)
         2'd0:    off = 19'sd65536;
         2'd1:    off = 19'sd0;
         2'd2:    off = -19'sd65536;
         default: off = -19'sd131072;
      endcase
      if (frac == 16'd0) return off + 19'sd65536;
      return signed'({3'b000, frac}) + off;
   endfunction

   // neighbour index mirrored once about the border, with an in-range flag on top
   function automatic logic [20:0] mirror(logic signed [32:0] p, logic [1:0] i,
                                          logic [6:0] sz, int mx);
      logic signed [19:0] f, l, e, szs, step;
      f    = 20'(p >>> 16);
      step = signed'(20'(i)) - ((p[15:0] == 16'd0) ? 20'sd2 : 20'sd1);
      l    = f + step;
      szs  = (int'(sz) > mx) ? 20'(mx) : signed'(20'(sz));
      if (l < 0) e = ~l;
      else if (l >= szs) e = (szs <<< 1) - l - 20'sd1;
      else e = l;
      return {(e >= 0) && (e < szs), 20'(e)};
   endfunction

   bsvg_pkg::state_type state_ff, state_in;

   // configuration
   logic signed [15:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [6:0]         size_x_ff, size_y_ff, size_z_ff;

   // query context
   logic [1:0]         mode_ff;
   logic signed [32:0] px_ff, py_ff, pz_ff;
   logic [bsvg_pkg::X_W-1:0] ix_ff [4];
   logic [bsvg_pkg::Y_W-1:0] iy_ff [4];
   logic [bsvg_pkg::Z_W-1:0] iz_ff [4];
   logic               ok_ff;
   logic signed [31:0] wx_ff [4];
   logic signed [31:0] wy_ff [4];
   logic signed [31:0] wz_ff [4];
   logic [3:0]         wc_ff;
   logic               launch_ff;

   // tap pipeline
   logic [6:0]         t_ff;
   logic               va_ff, vb_ff, vc_ff;
   logic [1:0]         xi_ff;
   logic signed [31:0] rd_data_ff, c_ff, wyz_ff, w_ff;
   logic signed [63:0] prod_ff;
   logic signed [67:0] acc_ff;

   // result register
   logic               rsp_valid_ff;
   logic signed [47:0] rsp_gradient_ff;
   logic               rsp_oor_ff;

   logic signed [31:0] mem [bsvg_pkg::STORE_DEPTH];

   logic               accept, load_accept;
   logic               issuing, drained, rsp_load, tap_start;
   logic [20:0]        mx_in [4];
   logic [20:0]        my_in [4];
   logic [20:0]        mz_in [4];
   logic               ok_in;
   logic [ADDR_W-1:0]  rd_addr;
   logic [1:0]         axis;
   logic [1:0]         ni;
   logic [15:0]        frac_sel;
   logic signed [67:0] g_full;

   bsvg_pkg::tap_req_type tap_req;
   bsvg_pkg::tap_rsp_type tap_rsp;

   assign accept      = req_valid && !req_stall;
   assign load_accept = accept && (req_mode == bsvg_pkg::MODE_LOAD);
   assign drained     = t_ff[6] && !va_ff && !vb_ff && !vc_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         size_x_ff   <= 7'd64;
         size_y_ff   <= 7'd64;
         size_z_ff   <= 7'd64;
      end else if (csr_we) begin
         case (csr_index)
            bsvg_pkg::CSR_ORIGIN_X: origin_x_ff <= signed'(csr_wdata);
            bsvg_pkg::CSR_ORIGIN_Y: origin_y_ff <= signed'(csr_wdata);
            bsvg_pkg::CSR_ORIGIN_Z: origin_z_ff <= signed'(csr_wdata);
            bsvg_pkg::CSR_SIZE_X:   size_x_ff   <= csr_wdata[6:0];
            bsvg_pkg::CSR_SIZE_Y:   size_y_ff   <= csr_wdata[6:0];
            bsvg_pkg::CSR_SIZE_Z:   size_z_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsvg_pkg::ST_IDLE:
            if (accept && (req_mode != bsvg_pkg::MODE_LOAD)) state_in = bsvg_pkg::ST_SETUP;
         bsvg_pkg::ST_SETUP:
            state_in = bsvg_pkg::ST_WEIGHT;
         bsvg_pkg::ST_WEIGHT:
            if (!ok_ff) state_in = bsvg_pkg::ST_FINISH;
            else if (tap_rsp.done && (wc_ff == 4'd11)) state_in = bsvg_pkg::ST_ACCUM;
         bsvg_pkg::ST_ACCUM:
            if (drained) state_in = bsvg_pkg::ST_FINISH;
         bsvg_pkg::ST_FINISH:
            if (!rsp_valid_ff || !rsp_stall) state_in = bsvg_pkg::ST_IDLE;
         default:
            state_in = bsvg_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = (state_ff != bsvg_pkg::ST_IDLE);
      issuing   = (state_ff == bsvg_pkg::ST_ACCUM) && !t_ff[6];
      tap_start = (state_ff == bsvg_pkg::ST_WEIGHT) && launch_ff && ok_ff;
      rsp_load  = (state_ff == bsvg_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bsvg_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // capture position relative to the origin
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         px_ff   <= 33'(req_pos_x) - 33'(signed'({origin_x_ff, 16'h0000}));
         py_ff   <= 33'(req_pos_y) - 33'(signed'({origin_y_ff, 16'h0000}));
         pz_ff   <= 33'(req_pos_z) - 33'(signed'({origin_z_ff, 16'h0000}));
      end
   end

   // neighbour indices, all twelve at once
   always_comb begin
      ok_in = 1'b1;
      for (int n = 0; n < 4; n++) begin
         mx_in[n] = mirror(px_ff, 2'(n), size_x_ff, bsvg_pkg::MAX_X);
         my_in[n] = mirror(py_ff, 2'(n), size_y_ff, bsvg_pkg::MAX_Y);
         mz_in[n] = mirror(pz_ff, 2'(n), size_z_ff, bsvg_pkg::MAX_Z);
         ok_in = ok_in && mx_in[n][20] && my_in[n][20] && mz_in[n][20];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == bsvg_pkg::ST_SETUP) begin
         ok_ff <= ok_in;
         for (int n = 0; n < 4; n++) begin
            ix_ff[n] <= mx_in[n][bsvg_pkg::X_W-1:0];
            iy_ff[n] <= my_in[n][bsvg_pkg::Y_W-1:0];
            iz_ff[n] <= mz_in[n][bsvg_pkg::Z_W-1:0];
         end
      end
   end

   // weight sequencing through the shared weight unit
   assign axis = wc_ff[3:2];
   assign ni   = wc_ff[1:0];

   always_comb begin
      case (axis)
         2'd0:    frac_sel = px_ff[15:0];
         2'd1:    frac_sel = py_ff[15:0];
         default: frac_sel = pz_ff[15:0];
      endcase
   end

   assign tap_req.start = tap_start;
   assign tap_req.deriv = (mode_ff == 2'(axis + 2'd1));
   assign tap_req.d     = tap_dist(frac_sel, ni);

   bsvg_tap u_tap (
      .clock   (clock),
      .reset   (reset),
      .tap_req (tap_req),
      .tap_rsp (tap_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff     <= '0;
         launch_ff <= 1'b0;
      end else if (state_ff == bsvg_pkg::ST_SETUP) begin
         wc_ff     <= '0;
         launch_ff <= 1'b1;
      end else if (tap_start) begin
         launch_ff <= 1'b0;
      end else if (tap_rsp.done) begin
         wc_ff     <= wc_ff + 4'd1;
         launch_ff <= (wc_ff != 4'd11);
      end
   end

   always_ff @(posedge clock) begin
      if (tap_rsp.done) begin
         case (axis)
            2'd0:    wx_ff[ni] <= tap_rsp.w;
            2'd1:    wy_ff[ni] <= tap_rsp.w;
            default: wz_ff[ni] <= tap_rsp.w;
         endcase
      end
   end

   // coefficient memory: load writes, query reads one tap per cycle
   assign rd_addr = ADDR_W'(iz_ff[t_ff[5:4]]) * PLANE + ADDR_W'(iy_ff[t_ff[3:2]]) * ROW
                  + ADDR_W'(ix_ff[t_ff[1:0]]);

   always_ff @(posedge clock) begin
      if (load_accept && (32'(req_load_address) < 32'(bsvg_pkg::STORE_DEPTH)))
         mem[ADDR_W'(req_load_address)] <= req_load_value;
      rd_data_ff <= mem[rd_addr];
   end

   // tap pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff  <= '0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (state_ff == bsvg_pkg::ST_SETUP) t_ff <= '0;
         else if (issuing) t_ff <= t_ff + 7'd1;
         va_ff <= issuing;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   // yz weight, full weight, coefficient product, sum
   always_ff @(posedge clock) begin
      wyz_ff  <= rnd30(64'(wy_ff[t_ff[3:2]]) * 64'(wz_ff[t_ff[5:4]]));
      xi_ff   <= t_ff[1:0];
      w_ff    <= rnd30(64'(wx_ff[xi_ff]) * 64'(wyz_ff));
      c_ff    <= rd_data_ff;
      prod_ff <= 64'(c_ff) * 64'(w_ff);
      if (state_ff == bsvg_pkg::ST_SETUP) acc_ff <= '0;
      else if (vc_ff) acc_ff <= acc_ff + 68'(prod_ff);
   end

   // sum is far inside 48 bits after rounding, so the truncation to 48 bits loses nothing
   assign g_full = (acc_ff + 68'sd536870912) >>> 30;

   // result register, parts the result side from the input side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_gradient_ff <= ok_ff ? 48'(g_full) : '0;
         rsp_oor_ff      <= !ok_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gradient     = rsp_gradient_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

/* design/bsvg_checker.sv */
module bsvg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_mode,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [47:0] rsp_gradient,
   input logic               rsp_out_of_range
);

   // an error result carries a zero gradient
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_gradient == '0)
      else $error("out of range result with nonzero gradient");

   // a query blocks the input side on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode != bsvg_pkg::MODE_LOAD) |=> req_stall)
      else $error("input taken while a query is in progress");

   // a load leaves the input side open
   a_load_open: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == bsvg_pkg::MODE_LOAD) |=> !req_stall)
      else $error("load blocked the input side");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gradient))
      else $error("stalled result changed");

endmodule

bind bspline_volume_gradient_sample bsvg_checker u_bsvg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_gradient     (rsp_gradient),
   .rsp_out_of_range (rsp_out_of_range)
);
